// ===== rtl/core/texsl_pkg.sv =====
// Package for the texture slot table allocator.
// Holds the codes, the slot entry and result types, and the size-bit helper.
// Has no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package texsl_pkg;
    localparam int SLOT_COUNT_DEF = 256;
    localparam logic [23:0] VRAM_BASE_RST = 24'd917504;
    localparam logic [15:0] MODEL_FLAG = 16'h2000;
    localparam logic [23:0] CLUT_WORDS_4 = 24'd128;
    localparam logic [23:0] CLUT_WORDS_8 = 24'd256;

    localparam logic [1:0] MODE_ADD    = 2'd0;
    localparam logic [1:0] MODE_LOOKUP = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    localparam logic [3:0] CT_SKIP_A   = 4'd1;
    localparam logic [3:0] CT_SKIP_B   = 4'd2;
    localparam logic [3:0] CT_CLUT     = 4'd3;
    localparam logic [3:0] CT_IMAGE_A  = 4'd4;
    localparam logic [3:0] CT_SCRIPT_A = 4'd5;
    localparam logic [3:0] CT_MODEL_A  = 4'd6;
    localparam logic [3:0] CT_IMAGE_B  = 4'd7;
    localparam logic [3:0] CT_MODEL_B  = 4'd9;
    localparam logic [3:0] CT_SCRIPT_B = 4'd10;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_SKIPPED   = 3'd3;
    localparam logic [2:0] ST_CHAIN_END = 3'd4;

    localparam logic [2:0] KIND_NONE   = 3'd0;
    localparam logic [2:0] KIND_CLUT   = 3'd3;
    localparam logic [2:0] KIND_IMAGE  = 3'd4;
    localparam logic [2:0] KIND_SCRIPT = 3'd5;
    localparam logic [2:0] KIND_MODEL  = 3'd6;

    typedef struct packed {
        logic [15:0] attr;
        logic [2:0]  kind;
        logic [15:0] base;
        logic [15:0] twidth;
    } t_entry;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  slot;
        logic [2:0]  kind;
        logic [15:0] attr;
        logic [15:0] base;
        logic [15:0] twidth;
        logic [4:0]  wlog2;
        logic [4:0]  hlog2;
    } t_res;

    // lowest set bit at position 1 and up, 0 if none
    function automatic logic [4:0] size_bit(input logic [10:0] v);
        logic [4:0] n;
        n = 5'd0;
        for (int i = 10; i >= 1; i--) begin
            if (v[i]) n = 5'(i);
        end
        return n;
    endfunction
endpackage
`default_nettype wire

// ===== rtl/core/texsl_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module texsl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        if (i_re) o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/core/texture_slot_table_allocator.sv =====
// Top level of the texture slot table allocator.
// Depends on texsl_pkg and texsl_ram.
//
// Usage:
//  - Input channel (i_in_valid / o_in_stall) takes one request beat: add a
//    chunk, look up a key, or clear the list. Output channel
//    (o_out_valid / i_out_stall) returns exactly one result beat per request.
//  - Config: i_cfg_we writes vram_base; the pointer picks it up at next clear.
//  - Slots are only ever taken first-free and freed all at once, so the used
//    slots are always 0..fill-1; a fill counter replaces per-slot valid bits.
//  - Slot data lives in one RAM with a registered read.
//  - Skip/end/full/clear go straight to S_DONE; script/model, palette and
//    unscaled image pass S_MUL and S_ALLOC; wide 4-bit image first runs the
//    11-step divider for the size scale, then one multiply. Lookup scans the
//    RAM one slot per cycle, so the scan over the table sets the worst case.
//  - One request in flight at a time; the next beat is taken once the
//    result sits in the output register, even if the receiver stalls.
//  - Reset empties the table, clears output valid and loads vram_base and
//    the pointer with the reset base. RAM contents are not cleared.
//  - While i_out_stall is high the result beat holds.
`timescale 1ns / 1ps
`default_nettype none
module texture_slot_table_allocator #(
    parameter int SLOT_COUNT = texsl_pkg::SLOT_COUNT_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [23:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_mode,
    input  wire logic [3:0]  i_chunk_type,
    input  wire logic [15:0] i_chunk_attr,
    input  wire logic [10:0] i_width,
    input  wire logic [10:0] i_height,
    input  wire logic        i_bpp_is_eight,
    input  wire logic [22:0] i_data_size,
    input  wire logic [7:0]  i_lookup_key,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [2:0]       o_status,
    output logic [7:0]       o_slot,
    output logic [2:0]       o_kind,
    output logic [15:0]      o_attr_out,
    output logic [15:0]      o_base_pointer,
    output logic [15:0]      o_transfer_width,
    output logic [4:0]       o_width_log2,
    output logic [4:0]       o_height_log2
);
    import texsl_pkg::*;

    localparam int IW = $clog2(SLOT_COUNT);
    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam int EW = $bits(t_entry);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_ALLOC = 3'd3;
    localparam logic [2:0] S_LOOK  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]  r_st;
    logic [23:0] r_base, r_ptr, r_adv;
    logic [CW-1:0] r_fill, r_idx, r_cidx;
    logic        r_pend;
    logic        r_ov;
    t_res        r_res, r_out;

    // latched request
    logic [3:0]  r_type;
    logic [15:0] r_attr;
    logic [10:0] r_w, r_h;
    logic        r_eight;
    logic [22:0] r_size;
    logic [7:0]  r_key;

    // divider: quotient shifts into r_dq as the dividend shifts out
    logic [10:0] r_dq;
    logic [11:0] r_rem;
    logic [3:0]  r_dcnt;

    t_entry      w_rd, w_wr;
    logic        w_acc, w_re, w_we;
    logic [12:0] w_trial;
    logic [11:0] w_dsor;
    logic        w_img, w_clut, w_script, w_model;
    logic [15:0] w_tw;

    // result with only a status code, all other fields zero
    function automatic t_res status_only(input logic [2:0] st);
        t_res v;
        v = '0;
        v.status = st;
        return v;
    endfunction

    assign w_acc = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_st != S_IDLE);

    assign w_img    = (r_type == CT_IMAGE_A) || (r_type == CT_IMAGE_B);
    assign w_clut   = (r_type == CT_CLUT);
    assign w_model  = (r_type == CT_MODEL_A) || (r_type == CT_MODEL_B);
    assign w_script = (r_type == CT_SCRIPT_A) || (r_type == CT_SCRIPT_B);

    assign w_dsor  = {r_h, 1'b0};
    assign w_trial = {r_rem, r_dq[10]};

    // scan reads while slots remain
    assign w_re = (r_st == S_LOOK) && (r_idx < r_fill);
    assign w_we = (r_st == S_ALLOC);

    always_comb begin
        if (w_clut) begin
            w_tw = 16'({r_w, 2'b00});
        end else if (!r_eight) begin
            w_tw = 16'(r_w >> 1);
        end else if (r_w < r_h) begin
            w_tw = (r_w != 11'd0) ? 16'(r_h) : 16'd0;
        end else begin
            w_tw = 16'(r_w);
        end
    end

    always_comb begin
        w_wr.attr   = w_model ? (r_attr | MODEL_FLAG) : r_attr;
        w_wr.kind   = w_clut ? KIND_CLUT : w_img ? KIND_IMAGE
                    : w_model ? KIND_MODEL : KIND_SCRIPT;
        w_wr.base   = (w_clut || w_img) ? r_ptr[21:6] : 16'd0;
        w_wr.twidth = (w_clut || w_img) ? w_tw : 16'd0;
    end

    texsl_ram #(
        .WIDTH(EW),
        .DEPTH(SLOT_COUNT)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(r_fill[IW-1:0]),
        .i_wdata(w_wr),
        .i_re   (w_re),
        .i_raddr(r_idx[IW-1:0]),
        .o_rdata(w_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_IDLE;
            r_base <= VRAM_BASE_RST;
            r_ptr  <= VRAM_BASE_RST;
            r_fill <= '0;
            r_ov   <= 1'b0;
            r_pend <= 1'b0;
        end else begin
            if (i_cfg_we) r_base <= i_cfg_data;
            // S_DONE owns r_ov while it loads the output register
            if (r_ov && !i_out_stall && r_st != S_DONE) r_ov <= 1'b0;

            unique case (r_st)
                S_IDLE: begin
                    if (w_acc) begin
                        r_type  <= i_chunk_type;
                        r_attr  <= i_chunk_attr;
                        r_w     <= i_width;
                        r_h     <= i_height;
                        r_eight <= i_bpp_is_eight;
                        r_size  <= i_data_size;
                        r_key   <= i_lookup_key;
                        r_idx   <= '0;
                        r_pend  <= 1'b0;
                        r_rem   <= '0;
                        r_dcnt  <= '0;
                        priority case (i_mode)
                            MODE_ADD: begin
                                priority if (i_chunk_type == CT_SKIP_A
                                          || i_chunk_type == CT_SKIP_B) begin
                                    r_res <= status_only(ST_SKIPPED);
                                    r_st <= S_DONE;
                                end else if (!(i_chunk_type == CT_CLUT
                                          || i_chunk_type == CT_IMAGE_A
                                          || i_chunk_type == CT_IMAGE_B
                                          || i_chunk_type == CT_SCRIPT_A
                                          || i_chunk_type == CT_SCRIPT_B
                                          || i_chunk_type == CT_MODEL_A
                                          || i_chunk_type == CT_MODEL_B)) begin
                                    r_res <= status_only(ST_CHAIN_END);
                                    r_st <= S_DONE;
                                end else if (r_fill == CW'(SLOT_COUNT)) begin
                                    r_res <= status_only(ST_FULL);
                                    r_st <= S_DONE;
                                end else if ((i_chunk_type == CT_IMAGE_A
                                          || i_chunk_type == CT_IMAGE_B)
                                          && !i_bpp_is_eight
                                          && i_height != 11'd0
                                          && {i_height, 1'b0} < {1'b0, i_width}) begin
                                    r_res <= '0;
                                    r_dq  <= i_width;
                                    r_st  <= S_DIV;
                                end else begin
                                    r_res <= '0;
                                    r_dq  <= 11'd1;   // unscaled size
                                    r_st  <= S_MUL;
                                end
                            end
                            MODE_LOOKUP: begin
                                r_res <= '0;
                                r_st  <= S_LOOK;
                            end
                            MODE_CLEAR: begin
                                r_res  <= '0;
                                r_fill <= '0;
                                r_ptr  <= r_base;
                                r_st   <= S_DONE;
                            end
                            default: begin
                                r_res <= '0;
                                r_st  <= S_DONE;
                            end
                        endcase
                    end
                end
                S_DIV: begin
                    if (w_trial >= {1'b0, w_dsor}) begin
                        r_rem <= 12'(w_trial - {1'b0, w_dsor});
                        r_dq  <= {r_dq[9:0], 1'b1};
                    end else begin
                        r_rem <= w_trial[11:0];
                        r_dq  <= {r_dq[9:0], 1'b0};
                    end
                    r_dcnt <= r_dcnt + 4'd1;
                    if (r_dcnt == 4'd10) r_st <= S_MUL;
                end
                S_MUL: begin
                    if (w_clut) begin
                        r_adv <= r_eight ? CLUT_WORDS_8 : CLUT_WORDS_4;
                    end else begin
                        r_adv <= 24'((34'(r_size) * 34'(r_dq)) >> 2);
                    end
                    r_st <= S_ALLOC;
                end
                S_ALLOC: begin
                    if (w_clut || w_img) begin
                        r_ptr <= r_ptr + r_adv;
                        r_res.wlog2 <= size_bit(r_w);
                        r_res.hlog2 <= size_bit(r_h);
                    end
                    r_res.status <= ST_OK;
                    r_res.slot   <= 8'(r_fill);
                    r_res.kind   <= w_wr.kind;
                    r_res.attr   <= w_wr.attr;
                    r_res.base   <= w_wr.base;
                    r_res.twidth <= w_wr.twidth;
                    r_fill <= r_fill + CW'(1);
                    r_st   <= S_DONE;
                end
                S_LOOK: begin
                    if (w_re) r_idx <= r_idx + CW'(1);
                    r_pend <= w_re;
                    r_cidx <= r_idx;
                    if (r_pend && w_rd.attr[7:0] == r_key) begin
                        r_res.status <= ST_OK;
                        r_res.slot   <= 8'(r_cidx);
                        r_res.kind   <= w_rd.kind;
                        r_res.attr   <= w_rd.attr;
                        if (w_rd.kind == KIND_CLUT || w_rd.kind == KIND_IMAGE) begin
                            r_res.base   <= w_rd.base;
                            r_res.twidth <= w_rd.twidth;
                        end
                        r_st <= S_DONE;
                    end else if (!r_pend && !w_re) begin
                        r_res.status <= ST_NOT_FOUND;
                        r_st <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_ov || !i_out_stall) begin
                        r_out <= r_res;
                        r_ov  <= 1'b1;
                        r_st  <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid      = r_ov;
    assign o_status         = r_out.status;
    assign o_slot           = r_out.slot;
    assign o_kind           = r_out.kind;
    assign o_attr_out       = r_out.attr;
    assign o_base_pointer   = r_out.base;
    assign o_transfer_width = r_out.twidth;
    assign o_width_log2     = r_out.wlog2;
    assign o_height_log2    = r_out.hlog2;
endmodule
`default_nettype wire

// ===== rtl/core/texsl_chk.sv =====
// Port-level checker for the texture slot table allocator, bound to the top.
// Depends on texsl_pkg and texture_slot_table_allocator.
`timescale 1ns / 1ps
`default_nettype none
module texsl_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_stall,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [2:0]  o_status,
    input wire logic [7:0]  o_slot,
    input wire logic [2:0]  o_kind,
    input wire logic [15:0] o_base_pointer,
    input wire logic [15:0] o_transfer_width
);
    import texsl_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result beat dropped while stalled");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second beat taken while busy");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |-> (o_slot == 8'd0 && o_kind == KIND_NONE))
        else $error("failed result carries slot data");

    a_nomem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_kind == KIND_SCRIPT || o_kind == KIND_MODEL))
        |-> (o_base_pointer == 16'd0 && o_transfer_width == 16'd0))
        else $error("script or model slot with memory fields");
endmodule

bind texture_slot_table_allocator texsl_chk u_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_status        (o_status),
    .o_slot          (o_slot),
    .o_kind          (o_kind),
    .o_base_pointer  (o_base_pointer),
    .o_transfer_width(o_transfer_width)
);
`default_nettype wire

// ===== dv/texture_slot_table_allocator_test.sv =====
// Self-checking bench for the texture slot table allocator.
// Drives random and directed chunk, lookup and clear beats; predicts each result.
// Depends on texsl_pkg and the allocator RTL.
`timescale 1ns / 1ps
module texture_slot_table_allocator_test;
    import texsl_pkg::*;

    localparam int NSLOT = 256;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [1:0]  mode;
        logic [3:0]  ctype;
        logic [15:0] attr;
        logic [10:0] w;
        logic [10:0] h;
        logic        eight;
        logic [22:0] size;
        logic [7:0]  key;
    } t_req;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [23:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    t_req req_q = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_res got;

    always #1 i_clk = ~i_clk;

    texture_slot_table_allocator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_mode(req_q.mode), .i_chunk_type(req_q.ctype), .i_chunk_attr(req_q.attr),
        .i_width(req_q.w), .i_height(req_q.h), .i_bpp_is_eight(req_q.eight),
        .i_data_size(req_q.size), .i_lookup_key(req_q.key),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_status(got.status), .o_slot(got.slot), .o_kind(got.kind),
        .o_attr_out(got.attr), .o_base_pointer(got.base),
        .o_transfer_width(got.twidth), .o_width_log2(got.wlog2),
        .o_height_log2(got.hlog2)
    );

    // predictor state
    logic        tbl_used [NSLOT];
    t_entry      tbl_ent  [NSLOT];
    logic [23:0] pred_ptr;
    logic [23:0] pred_base;

    t_req pending_beats[$];
    t_res expected_results[$];
    int   fails = 0;
    int   cycles = 0;
    bit   calm = 0;        // no idling stretch
    bit   hold_send = 0;   // sender pause

    function automatic logic [4:0] low_bit(input logic [10:0] v);
        for (int n = 1; n <= 10; n++)
            if (v[n]) return 5'(n);
        return 5'd0;
    endfunction

    function automatic t_res predict_slot_result(input t_req r);
        t_res o;
        int s;
        logic [63:0] sz;
        logic [23:0] adv;
        logic [31:0] tw;
        logic [15:0] a;
        logic [2:0]  k;
        o = '0;
        sz = 64'(r.size);
        if (r.mode == MODE_ADD) begin
            if (r.ctype == CT_SKIP_A || r.ctype == CT_SKIP_B) begin
                o.status = ST_SKIPPED;
            end else if (r.ctype inside {CT_CLUT, CT_IMAGE_A, CT_IMAGE_B, CT_SCRIPT_A,
                                         CT_SCRIPT_B, CT_MODEL_A, CT_MODEL_B}) begin
                s = -1;
                for (int i = 0; i < NSLOT; i++)
                    if (s < 0 && !tbl_used[i]) s = i;
                if (s < 0) begin
                    o.status = ST_FULL;
                end else begin
                    a = r.attr; tw = 0;
                    o.base = '0;
                    if (r.ctype inside {CT_CLUT, CT_IMAGE_A, CT_IMAGE_B}) begin
                        if (r.ctype == CT_CLUT) begin
                            k = KIND_CLUT;
                            tw = 32'(r.w) * 4;
                            adv = r.eight ? CLUT_WORDS_8 : CLUT_WORDS_4;
                        end else begin
                            k = KIND_IMAGE;
                            if (!r.eight) begin
                                tw = 32'(r.w >> 1);
                                if (r.h != 0 && 32'(r.h) * 2 < 32'(r.w))
                                    sz = sz * 64'(32'(r.w) / (32'(r.h) * 2));
                            end else if (r.w < r.h) begin
                                tw = (r.w != 0) ? 32'(r.h) : 0;
                            end else begin
                                tw = 32'(r.w);
                            end
                            adv = 24'(sz >> 2);
                        end
                        o.base = pred_ptr[21:6];
                        pred_ptr = pred_ptr + adv;
                        o.wlog2 = low_bit(r.w);
                        o.hlog2 = low_bit(r.h);
                    end else if (r.ctype == CT_MODEL_A || r.ctype == CT_MODEL_B) begin
                        k = KIND_MODEL;
                        a = a | MODEL_FLAG;
                    end else begin
                        k = KIND_SCRIPT;
                    end
                    tbl_used[s] = 1'b1;
                    tbl_ent[s] = '{attr: a, kind: k, base: o.base, twidth: tw[15:0]};
                    o.status = ST_OK; o.slot = 8'(s); o.kind = k;
                    o.attr = a; o.twidth = tw[15:0];
                end
            end else begin
                o.status = ST_CHAIN_END;
            end
        end else if (r.mode == MODE_LOOKUP) begin
            o.status = ST_NOT_FOUND;
            for (int i = 0; i < NSLOT; i++) begin
                if (o.status == ST_NOT_FOUND && tbl_used[i] &&
                    tbl_ent[i].attr[7:0] == r.key) begin
                    o.status = ST_OK; o.slot = 8'(i);
                    o.kind = tbl_ent[i].kind; o.attr = tbl_ent[i].attr;
                    if (o.kind == KIND_CLUT || o.kind == KIND_IMAGE) begin
                        o.base = tbl_ent[i].base; o.twidth = tbl_ent[i].twidth;
                    end
                end
            end
        end else if (r.mode == MODE_CLEAR) begin
            for (int i = 0; i < NSLOT; i++) tbl_used[i] = 1'b0;
            pred_ptr = pred_base;
        end
        return o;
    endfunction

    // driver: a beat moves when valid & !stall; hold payload while stalled
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                expected_results.push_back(predict_slot_result(req_q));
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pending_beats.size() != 0 && !hold_send &&
                    (calm || $urandom_range(99) >= 28)) begin
                    i_in_valid <= 1'b1;
                    req_q <= pending_beats.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_stall <= !calm && $urandom_range(99) < 28;
        end
    end

    // monitor: compare each result beat with the oldest prediction
    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $error("result beat with nothing expected");
                fails = fails + 1;
            end else begin
                e = expected_results.pop_front();
                if (got.status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, got.status); fails = fails + 1;
                end
                if (got.slot !== e.slot) begin
                    $error("slot exp %0d got %0d", e.slot, got.slot); fails = fails + 1;
                end
                if (got.kind !== e.kind) begin
                    $error("kind exp %0d got %0d", e.kind, got.kind); fails = fails + 1;
                end
                if (got.attr !== e.attr) begin
                    $error("attr_out exp %h got %h", e.attr, got.attr); fails = fails + 1;
                end
                if (got.base !== e.base) begin
                    $error("base_pointer exp %h got %h", e.base, got.base); fails = fails + 1;
                end
                if (got.twidth !== e.twidth) begin
                    $error("transfer_width exp %0d got %0d", e.twidth, got.twidth);
                    fails = fails + 1;
                end
                if (got.wlog2 !== e.wlog2) begin
                    $error("width_log2 exp %0d got %0d", e.wlog2, got.wlog2); fails = fails + 1;
                end
                if (got.hlog2 !== e.hlog2) begin
                    $error("height_log2 exp %0d got %0d", e.hlog2, got.hlog2);
                    fails = fails + 1;
                end
            end
        end
    end

    // timeout watchdog
    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic t_req mk(input logic [1:0] m, input logic [3:0] t,
                                input logic [15:0] a, input logic [10:0] w,
                                input logic [10:0] h, input logic e,
                                input logic [22:0] s, input logic [7:0] k);
        return '{mode: m, ctype: t, attr: a, w: w, h: h, eight: e, size: s, key: k};
    endfunction

    // random beat; mostly real chunks, small keys so lookups hit
    function automatic t_req rand_beat();
        t_req r;
        int p;
        logic [3:0] types [9] = '{CT_CLUT, CT_IMAGE_A, CT_IMAGE_B, CT_SCRIPT_A,
                                  CT_SCRIPT_B, CT_MODEL_A, CT_MODEL_B, CT_SKIP_A, 4'd0};
        p = $urandom_range(99);
        r.attr = 16'($urandom);
        if ($urandom_range(1)) r.attr[7:0] = 8'($urandom_range(15));
        r.w = ($urandom_range(3) == 0) ? 11'(1 << $urandom_range(10))
                                       : 11'($urandom_range(1024));
        r.h = ($urandom_range(3) == 0) ? 11'(1 << $urandom_range(10))
                                       : 11'($urandom_range(1024));
        if ($urandom_range(7) == 0) r.h = 11'($urandom_range(4));
        r.eight = 1'($urandom);
        r.size = ($urandom_range(9) == 0) ? 23'd4194304 : 23'($urandom_range(65536));
        r.key = ($urandom_range(1)) ? 8'($urandom_range(15)) : 8'($urandom);
        r.ctype = 4'($urandom);
        if (p < 60) begin
            r.mode = MODE_ADD; r.ctype = types[$urandom_range(6)];
        end else if (p < 70) begin
            r.mode = MODE_ADD;
        end else if (p < 93) begin
            r.mode = MODE_LOOKUP;
        end else if (p < 97) begin
            r.mode = MODE_CLEAR;
        end else begin
            r.mode = 2'd3;
        end
        return r;
    endfunction

    task automatic wait_drained();
        while (pending_beats.size() != 0 || i_in_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (300) @(posedge i_clk);   // worst lookup scan
    endtask

    task automatic set_base(input logic [23:0] v);
        wait_drained();
        @(posedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_data <= v;
        pred_base = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        pending_beats.push_back(mk(MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0));
    endtask

    initial begin
        logic [23:0] bases [4] = '{24'hFFFFFF, 24'h000000, 24'hFFFFC0, 24'h00ABC5};
        for (int i = 0; i < NSLOT; i++) begin
            tbl_used[i] = 1'b0; tbl_ent[i] = '0;
        end
        pred_base = VRAM_BASE_RST;
        pred_ptr = VRAM_BASE_RST;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: every type, field extremes, wide and tall corner cases
        pending_beats.push_back(mk(MODE_LOOKUP, 0, 0, 0, 0, 0, 0, 8'h00));
        pending_beats.push_back(mk(MODE_ADD, CT_CLUT, 16'hFFFF, 11'd1024, 11'd1, 1, 0, 0));
        pending_beats.push_back(mk(MODE_ADD, CT_CLUT, 16'h0001, 11'd16, 11'd1, 0, 0, 0));
        pending_beats.push_back(mk(MODE_ADD, CT_IMAGE_A, 16'h0002, 11'd1024, 11'd1, 0,
                                   23'd4194304, 0));
        pending_beats.push_back(mk(MODE_ADD, CT_IMAGE_B, 16'h0003, 11'd512, 11'd0, 0,
                                   23'd1000, 0));   // zero height, no scale
        pending_beats.push_back(mk(MODE_ADD, CT_IMAGE_A, 16'h0004, 11'd0, 11'd64, 1,
                                   23'd256, 0));    // zero width, tall 8-bit
        pending_beats.push_back(mk(MODE_ADD, CT_IMAGE_B, 16'h0005, 11'd32, 11'd1024, 1,
                                   23'd7, 0));
        pending_beats.push_back(mk(MODE_ADD, CT_SCRIPT_A, 16'h0006, 0, 0, 0, 0, 0));
        pending_beats.push_back(mk(MODE_ADD, CT_SCRIPT_B, 16'h0007, 0, 0, 0, 0, 0));
        pending_beats.push_back(mk(MODE_ADD, CT_MODEL_A, 16'h0008, 0, 0, 0, 0, 0));
        pending_beats.push_back(mk(MODE_ADD, CT_MODEL_B, 16'hDF09, 0, 0, 0, 0, 0));
        pending_beats.push_back(mk(MODE_ADD, CT_SKIP_A, 16'h1111, 0, 0, 0, 0, 0));
        pending_beats.push_back(mk(MODE_ADD, CT_SKIP_B, 16'h2222, 0, 0, 0, 0, 0));
        pending_beats.push_back(mk(MODE_ADD, 4'd0, 0, 0, 0, 0, 0, 0));
        pending_beats.push_back(mk(MODE_ADD, 4'd15, 0, 0, 0, 0, 0, 0));
        pending_beats.push_back(mk(MODE_LOOKUP, 0, 0, 0, 0, 0, 0, 8'h09));
        pending_beats.push_back(mk(MODE_LOOKUP, 0, 0, 0, 0, 0, 0, 8'h02));
        pending_beats.push_back(mk(MODE_LOOKUP, 0, 0, 0, 0, 0, 0, 8'hFF));
        pending_beats.push_back(mk(MODE_LOOKUP, 0, 0, 0, 0, 0, 0, 8'h77));
        pending_beats.push_back(mk(2'd3, 4'hF, 16'hFFFF, 11'h7FF, 11'h7FF, 1,
                                   23'h7FFFFF, 8'hFF));
        // fill the table to overflow, then look up key FF, which the first slot holds
        for (int i = 0; i < NSLOT + 2; i++)
            pending_beats.push_back(mk(MODE_ADD, CT_SCRIPT_A, 16'(i), 0, 0, 0, 0, 0));
        pending_beats.push_back(mk(MODE_LOOKUP, 0, 0, 0, 0, 0, 0, 8'hFF));
        pending_beats.push_back(mk(MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0));

        // pressure: midway through the fill, sender waits until every result is back
        while (pending_beats.size() > 100) @(posedge i_clk);
        hold_send = 1;
        while (expected_results.size() != 0 || i_in_valid) @(posedge i_clk);
        hold_send = 0;

        for (int ph = 0; ph < 4; ph++) begin
            set_base(bases[ph]);
            calm = (ph == 2);
            for (int n = 0; n < 180; n++) pending_beats.push_back(rand_beat());
        end
        calm = 0;
        wait_drained();
        if (fails == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

// ===== texture_slot_table_allocator.f =====
rtl/core/texsl_pkg.sv
rtl/core/texsl_ram.sv
rtl/core/texture_slot_table_allocator.sv
rtl/core/texsl_chk.sv
dv/texture_slot_table_allocator_test.sv
